FILE: rtl/core/i2ms_pkg.sv
// Shared constants and types for the 2x2 mean subsampler.
package i2ms_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int CFG_BITS    = 11;
    localparam int POS_BITS    = $clog2(MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS);
    localparam int STORE_DEPTH = (MAX_COLS + 1) / 2;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int OROW_BITS   = 9;
    localparam int PAIR_BITS   = PIXEL_BITS + 1;
    localparam int SUM_BITS    = PIXEL_BITS + 2;
    localparam int CFG_IDX_BITS = 2;

    // job queue and result queue depths
    localparam int JQ_DEPTH    = 4;
    localparam int JQ_PTR_BITS = $clog2(JQ_DEPTH);
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROWS_IN_USE = 2'd0,
        CFG_COLS_IN_USE = 2'd1
    } cfg_index_t;

    // one completed horizontal pair, handed from front to back
    typedef struct packed {
        logic [PAIR_BITS-1:0] pair_sum;
        logic [ADDR_BITS-1:0] col_pair;
        logic [OROW_BITS-1:0] out_row;
        logic                 row_odd;
        logic                 col_odd;
        logic                 store_wr;
        logic                 frame_last;
    } job_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] block_mean;
        logic [OROW_BITS-1:0]  out_row;
        logic [ADDR_BITS-1:0]  out_col;
        logic                  frame_last;
    } result_t;

endpackage

FILE: rtl/core/i2ms_front.sv
// Front end: config registers, raster position tracking and pair summing.
module i2ms_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [i2ms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [i2ms_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic                                 accept,
    input  logic [i2ms_pkg::PIXEL_BITS-1:0]      pixel,
    output logic                                 job_push,
    output i2ms_pkg::job_t                       job
);

    logic [i2ms_pkg::CFG_BITS-1:0]  rows_reg, rows_next;
    logic [i2ms_pkg::CFG_BITS-1:0]  cols_reg, cols_next;
    logic [i2ms_pkg::POS_BITS-1:0]  row_pos_reg, row_pos_next;
    logic [i2ms_pkg::POS_BITS-1:0]  col_pos_reg, col_pos_next;
    logic [i2ms_pkg::PAIR_BITS-1:0] pair_sum_reg, pair_sum_next;
    logic [i2ms_pkg::CFG_BITS-1:0]  cfg_clamped;
    logic                           col_odd;
    logic                           row_odd;
    logic                           last_col;
    logic                           last_row;

    // zero counts as one, above max saturates
    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamped = i2ms_pkg::CFG_BITS'(1);
        else if (cfg_index == i2ms_pkg::CFG_ROWS_IN_USE
                 && cfg_data > i2ms_pkg::CFG_BITS'(i2ms_pkg::MAX_ROWS))
            cfg_clamped = i2ms_pkg::CFG_BITS'(i2ms_pkg::MAX_ROWS);
        else if (cfg_index == i2ms_pkg::CFG_COLS_IN_USE
                 && cfg_data > i2ms_pkg::CFG_BITS'(i2ms_pkg::MAX_COLS))
            cfg_clamped = i2ms_pkg::CFG_BITS'(i2ms_pkg::MAX_COLS);
        else
            cfg_clamped = cfg_data;
    end

    assign col_odd  = col_pos_reg[0];
    assign row_odd  = row_pos_reg[0];
    assign last_col = (i2ms_pkg::CFG_BITS'(col_pos_reg) + i2ms_pkg::CFG_BITS'(1)) >= cols_reg;
    assign last_row = (i2ms_pkg::CFG_BITS'(row_pos_reg) + i2ms_pkg::CFG_BITS'(1)) >= rows_reg;

    always_comb
    begin
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        pair_sum_next = pair_sum_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                i2ms_pkg::CFG_ROWS_IN_USE:
                begin
                    rows_next     = cfg_clamped;
                    row_pos_next  = '0;
                    col_pos_next  = '0;
                    pair_sum_next = '0;
                end
                i2ms_pkg::CFG_COLS_IN_USE:
                begin
                    cols_next     = cfg_clamped;
                    row_pos_next  = '0;
                    col_pos_next  = '0;
                    pair_sum_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (col_odd)
                pair_sum_next = pair_sum_reg + i2ms_pkg::PAIR_BITS'(pixel);
            else
                pair_sum_next = i2ms_pkg::PAIR_BITS'(pixel);
            if (last_col)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + i2ms_pkg::POS_BITS'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + i2ms_pkg::POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= i2ms_pkg::CFG_BITS'(i2ms_pkg::MAX_ROWS);
            cols_reg     <= i2ms_pkg::CFG_BITS'(i2ms_pkg::MAX_COLS);
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            pair_sum_reg <= '0;
        end
        else
        begin
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            pair_sum_reg <= pair_sum_next;
        end
    end

    // a job leaves for every closed horizontal pair
    assign job_push       = accept && !cfg_valid && (col_odd || last_col);
    assign job.pair_sum   = pair_sum_next;
    assign job.col_pair   = col_pos_reg[i2ms_pkg::POS_BITS-1:1];
    assign job.out_row    = row_pos_reg[i2ms_pkg::POS_BITS-1:1];
    assign job.row_odd    = row_odd;
    assign job.col_odd    = col_odd;
    assign job.store_wr   = !row_odd && !last_row;
    assign job.frame_last = last_row && last_col;

endmodule

FILE: rtl/core/i2ms_job_fifo.sv
// Short job queue between front and back.
module i2ms_job_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  i2ms_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output i2ms_pkg::job_t rd_job
);

    i2ms_pkg::job_t                   slot_reg [i2ms_pkg::JQ_DEPTH];
    logic [i2ms_pkg::JQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [i2ms_pkg::JQ_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [i2ms_pkg::JQ_PTR_BITS:0]   count_reg, count_next;
    logic                             do_wr;
    logic                             do_rd;

    assign full     = count_reg == (i2ms_pkg::JQ_PTR_BITS+1)'(i2ms_pkg::JQ_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + i2ms_pkg::JQ_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + i2ms_pkg::JQ_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (i2ms_pkg::JQ_PTR_BITS+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (i2ms_pkg::JQ_PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

FILE: rtl/core/i2ms_back.sv
// Back end: column-pair line store, block mean and result queue.
module i2ms_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    input  i2ms_pkg::job_t                      job,
    output logic                                job_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [i2ms_pkg::PIXEL_BITS-1:0]     block_mean,
    output logic [i2ms_pkg::OROW_BITS-1:0]      out_row,
    output logic [i2ms_pkg::ADDR_BITS-1:0]      out_col,
    output logic                                frame_last
);

    logic [i2ms_pkg::PAIR_BITS-1:0]   line_mem [i2ms_pkg::STORE_DEPTH];
    logic [i2ms_pkg::PAIR_BITS-1:0]   rd_data_reg;
    i2ms_pkg::job_t                   s1_job_reg;
    logic                             s1_valid_reg, s1_valid_next;
    logic [i2ms_pkg::SUM_BITS-1:0]    block_sum;
    logic [1:0]                       shift;
    logic [i2ms_pkg::SUM_BITS-1:0]    shifted;
    i2ms_pkg::result_t                s1_result;

    i2ms_pkg::result_t                oq_reg [i2ms_pkg::OQ_DEPTH];
    logic [i2ms_pkg::OQ_PTR_BITS-1:0] oq_wr_ptr_reg, oq_wr_ptr_next;
    logic [i2ms_pkg::OQ_PTR_BITS-1:0] oq_rd_ptr_reg, oq_rd_ptr_next;
    logic [i2ms_pkg::OQ_PTR_BITS:0]   oq_count_reg, oq_count_next;
    logic [i2ms_pkg::OQ_PTR_BITS:0]   committed;
    logic                             oq_rd;

    // issue only when the result queue has a slot for anything in flight
    assign committed = oq_count_reg + (i2ms_pkg::OQ_PTR_BITS+1)'(s1_valid_reg);
    assign job_pop   = job_valid
                       && committed < (i2ms_pkg::OQ_PTR_BITS+1)'(i2ms_pkg::OQ_DEPTH);
    assign s1_valid_next = job_pop && !job.store_wr;

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            if (job.store_wr)
                line_mem[job.col_pair] <= job.pair_sum;
            else
                rd_data_reg <= line_mem[job.col_pair];
            s1_job_reg <= job;
        end
    end

    // sum of in-image pixels, then divide by 1, 2 or 4
    always_comb
    begin
        block_sum = i2ms_pkg::SUM_BITS'(s1_job_reg.pair_sum);
        if (s1_job_reg.row_odd)
            block_sum = block_sum + i2ms_pkg::SUM_BITS'(rd_data_reg);
        shift   = {1'b0, s1_job_reg.col_odd} + {1'b0, s1_job_reg.row_odd};
        shifted = block_sum >> shift;
        s1_result.block_mean = shifted[i2ms_pkg::PIXEL_BITS-1:0];
        s1_result.out_row    = s1_job_reg.out_row;
        s1_result.out_col    = s1_job_reg.col_pair;
        s1_result.frame_last = s1_job_reg.frame_last;
    end

    assign empty = oq_count_reg == '0;
    assign oq_rd = pop && !empty;

    always_comb
    begin
        oq_wr_ptr_next = s1_valid_reg ? oq_wr_ptr_reg + i2ms_pkg::OQ_PTR_BITS'(1)
                                      : oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_rd ? oq_rd_ptr_reg + i2ms_pkg::OQ_PTR_BITS'(1) : oq_rd_ptr_reg;
        oq_count_next  = oq_count_reg;
        if (s1_valid_reg && !oq_rd)
            oq_count_next = oq_count_reg + (i2ms_pkg::OQ_PTR_BITS+1)'(1);
        else if (oq_rd && !s1_valid_reg)
            oq_count_next = oq_count_reg - (i2ms_pkg::OQ_PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            oq_reg[oq_wr_ptr_reg] <= s1_result;
    end

    assign block_mean = oq_reg[oq_rd_ptr_reg].block_mean;
    assign out_row    = oq_reg[oq_rd_ptr_reg].out_row;
    assign out_col    = oq_reg[oq_rd_ptr_reg].out_col;
    assign frame_last = oq_reg[oq_rd_ptr_reg].frame_last;

endmodule

FILE: rtl/core/image_2x2_mean_subsample.sv
// Top level of the 2x2 box-mean image subsampler.
//
// Takes one pixel per clock in raster order while full is low and
// returns, for every 2x2 block, the truncated mean of the block's pixels
// that lie inside the frame, tagged with its output row, output column
// and an end-of-frame flag. With an odd row or column count the last
// blocks hold two or one pixels and divide by 2 or 1. Sustained rate is
// one pixel per clock while results are popped; a result passes through
// the job queue, the line store's registered read and the result queue
// write that follows the summing logic before it leaves the result
// queue. The front end tracks position and sums horizontal pairs,
// a four-entry job queue decouples it from the back end, which holds a
// 512 x 17-bit line store of even-row pair sums and a four-entry result
// queue. The line store is not cleared; every frame writes an entry
// before reading it. Registers: index 0 is rows_in_use, index 1 is
// cols_in_use (0 reads as 1, above 1024 saturates); any write restarts
// the frame and must be done while no request is in flight. The config
// channel is always ready.
module image_2x2_mean_subsample
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [i2ms_pkg::PIXEL_BITS-1:0]      pixel,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [i2ms_pkg::PIXEL_BITS-1:0]      block_mean,
    output logic [i2ms_pkg::OROW_BITS-1:0]       out_row,
    output logic [i2ms_pkg::ADDR_BITS-1:0]       out_col,
    output logic                                 frame_last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [i2ms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [i2ms_pkg::CFG_BITS-1:0]        cfg_data
);

    logic           accept;
    logic           job_push;
    i2ms_pkg::job_t front_job;
    logic           jq_valid;
    logic           jq_pop;
    i2ms_pkg::job_t jq_job;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    i2ms_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (pixel),
        .job_push  (job_push),
        .job       (front_job)
    );

    i2ms_job_fifo u_job_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (front_job),
        .full     (full),
        .rd_en    (jq_pop),
        .rd_valid (jq_valid),
        .rd_job   (jq_job)
    );

    i2ms_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (jq_valid),
        .job        (jq_job),
        .job_pop    (jq_pop),
        .empty      (empty),
        .pop        (pop),
        .block_mean (block_mean),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

endmodule
